### rtl/vic_pkg.sv
// ---------------------------------------------------------------------------
// vic_pkg
// Shared types, command codes and reset constants for the vectored
// interrupt controller.
// ---------------------------------------------------------------------------
package vic_pkg;

	localparam int NUM_SOURCES = 13;
	localparam int SRC_W       = 4;
	localparam int LEVELS      = 8;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [2:0] CMD_ASSERT   = 3'd0;
	localparam logic [2:0] CMD_WITHDRAW = 3'd1;
	localparam logic [2:0] CMD_ACK      = 3'd2;
	localparam logic [2:0] CMD_WCTRL    = 3'd3;
	localparam logic [2:0] CMD_WMASK    = 3'd4;

	localparam logic [15:0] MASK_RESET   = 16'h3FFE;
	localparam logic [3:0]  COUNT_MAX    = 4'd15;
	localparam logic [7:0]  AUTOVEC_BASE = 8'd24;

	// bits that can ever be set in the pending word
	localparam logic [15:0] PEND_LEGAL = 16'((32'd1 << (NUM_SOURCES + 1)) - 32'd2);

	localparam logic [7:0] CTRL_RESET [16] = '{
		8'h00, 8'h04, 8'h08, 8'h0C, 8'h10, 8'h14, 8'h18, 8'h1C,
		8'h1C, 8'h80, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
	};

	typedef enum logic [2:0] {
		OP_NOP,
		OP_ASSERT,
		OP_WITHDRAW,
		OP_ACK,
		OP_WCTRL,
		OP_WMASK
	} op_kind_t;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [3:0]  source;
		logic [7:0]  device_vector;
		logic [2:0]  ack_level;
		logic [15:0] write_data;
	} vic_in_t;

	typedef struct packed {
		logic        raise_request;
		logic        drop_request;
		logic [2:0]  request_level;
		logic        ack_found;
		logic [7:0]  ack_vector;
		logic [15:0] pending_bits;
	} vic_out_t;

	typedef struct packed {
		op_kind_t    op;
		logic [3:0]  source;
		logic [7:0]  device_vector;
		logic [2:0]  ack_level;
		logic [15:0] write_data;
	} vic_op_t;

endpackage

### rtl/vic_front.sv
// ---------------------------------------------------------------------------
// vic_front
// Accepts items, decodes the command and checks the source number, and
// holds decoded items in a short queue for the back end.
// ---------------------------------------------------------------------------
module vic_front
	import vic_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    req_valid,
	output logic    req_ready,
	input  vic_in_t req,
	output logic    q_valid,
	input  logic    q_ready,
	output vic_op_t q_item
);

	vic_op_t           mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	vic_op_t           dec;
	logic              src_ok;
	logic              push;
	logic              pop;

	assign src_ok = (req.source != '0) && (req.source <= SRC_W'(NUM_SOURCES));

	always_comb begin
		dec.source        = req.source;
		dec.device_vector = req.device_vector;
		dec.ack_level     = req.ack_level;
		dec.write_data    = req.write_data;
		case (req.cmd)
			CMD_ASSERT:   dec.op = src_ok ? OP_ASSERT : OP_NOP;
			CMD_WITHDRAW: dec.op = src_ok ? OP_WITHDRAW : OP_NOP;
			CMD_ACK:      dec.op = OP_ACK;
			CMD_WCTRL:    dec.op = src_ok ? OP_WCTRL : OP_NOP;
			CMD_WMASK:    dec.op = OP_WMASK;
			default:      dec.op = OP_NOP;
		endcase
	end

	assign req_ready = (count_q != QCNT_W'(QUEUE_DEPTH));
	assign q_valid   = (count_q != '0);
	assign q_item    = mem_q[rd_ptr_q];
	assign push      = req_valid && req_ready;
	assign pop       = q_valid && q_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QUEUE_DEPTH))
		else $error("queue count above depth");

	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue count missed a push");

	a_count_down: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !push) |=> (count_q == $past(count_q) - 1'b1))
		else $error("queue count missed a pop");

endmodule

### rtl/vic_back.sv
// ---------------------------------------------------------------------------
// vic_back
// Holds control bytes, mask, pending word, stored vectors and level counts.
// Executes one decoded item at a time; an acknowledge scans the sources
// one per cycle. Results leave through an output register.
// ---------------------------------------------------------------------------
module vic_back
	import vic_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     q_valid,
	output logic     q_ready,
	input  vic_op_t  q_item,
	output logic     rsp_valid,
	input  logic     rsp_ready,
	output vic_out_t rsp
);

	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} state_t;

	state_t           state_q;
	logic [7:0]       control_q [1:NUM_SOURCES];
	logic [7:0]       vec_q     [1:NUM_SOURCES];
	logic [3:0]       count_q   [LEVELS];
	logic [15:0]      mask_q;
	logic [15:0]      pending_q;
	logic [SRC_W-1:0] scan_idx_q;
	logic [2:0]       ack_lev_q;
	logic             rsp_valid_q;
	vic_out_t         rsp_q;

	logic [SRC_W-1:0] idx;
	logic [7:0]       cb;
	logic [2:0]       lev;
	logic [3:0]       cnt;
	logic             pend_bit;
	logic             masked;
	logic             slot_free;
	logic             pop;
	logic             hit;
	logic             last;
	logic             rsp_load;
	logic [15:0]      pend_nxt;
	vic_out_t         rsp_nxt;
	vic_out_t         scan_rsp;

	assign idx       = (state_q == ST_SCAN) ? scan_idx_q : q_item.source;
	assign cb        = control_q[idx];
	assign lev       = cb[4:2];
	assign cnt       = count_q[lev];
	assign pend_bit  = pending_q[idx];
	assign masked    = mask_q[idx];
	assign slot_free = !rsp_valid_q || rsp_ready;
	assign q_ready   = (state_q == ST_IDLE) && slot_free;
	assign pop       = q_valid && q_ready;
	assign hit       = pend_bit && (lev == ack_lev_q);
	assign last      = (scan_idx_q == SRC_W'(NUM_SOURCES));
	assign rsp_load  = (pop && q_item.op != OP_ACK)
		|| ((state_q == ST_SCAN) && (hit || last) && slot_free);

	always_comb begin
		rsp_nxt  = '0;
		pend_nxt = pending_q;
		case (q_item.op)
			OP_ASSERT: begin
				if (!masked && !pend_bit) begin
					pend_nxt[idx]         = 1'b1;
					rsp_nxt.raise_request = 1'b1;
					rsp_nxt.request_level = lev;
				end
			end
			OP_WITHDRAW: begin
				if (!masked && pend_bit) begin
					pend_nxt[idx] = 1'b0;
					if (cnt == 4'd1) begin
						rsp_nxt.drop_request  = 1'b1;
						rsp_nxt.request_level = lev;
					end
				end
			end
			default: ;
		endcase
		rsp_nxt.pending_bits = pend_nxt;
	end

	always_comb begin
		scan_rsp              = '0;
		scan_rsp.pending_bits = pending_q;
		if (hit) begin
			scan_rsp.ack_found  = 1'b1;
			scan_rsp.ack_vector = cb[7] ? (AUTOVEC_BASE + {5'd0, ack_lev_q}) : vec_q[idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mask_q      <= MASK_RESET;
			pending_q   <= '0;
			scan_idx_q  <= SRC_W'(1);
			ack_lev_q   <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
			for (int i = 1; i <= NUM_SOURCES; i++) begin
				control_q[i] <= CTRL_RESET[i];
				vec_q[i]     <= '0;
			end
			for (int l = 0; l < LEVELS; l++) begin
				count_q[l] <= '0;
			end
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						pending_q <= pend_nxt;
						if (q_item.op == OP_ACK) begin
							state_q    <= ST_SCAN;
							scan_idx_q <= SRC_W'(1);
							ack_lev_q  <= q_item.ack_level;
						end else begin
							rsp_q <= rsp_nxt;
						end
						case (q_item.op)
							OP_ASSERT: begin
								if (!masked) begin
									vec_q[idx] <= q_item.device_vector;
									if (!pend_bit && cnt != COUNT_MAX) begin
										count_q[lev] <= cnt + 4'd1;
									end
								end
							end
							OP_WITHDRAW: begin
								if (!masked) begin
									vec_q[idx] <= '0;
									if (pend_bit && cnt != '0) begin
										count_q[lev] <= cnt - 4'd1;
									end
								end
							end
							OP_WCTRL:  control_q[idx] <= q_item.write_data[7:0];
							OP_WMASK:  mask_q <= q_item.write_data;
							default: ;
						endcase
					end
				end
				ST_SCAN: begin
					if (hit || last) begin
						// hold the scan until the output slot frees up
						if (slot_free) begin
							rsp_q   <= scan_rsp;
							state_q <= ST_IDLE;
						end
					end else begin
						scan_idx_q <= scan_idx_q + SRC_W'(1);
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_pend_legal: assert property (@(posedge clk) disable iff (!arst_n)
		(pending_q & ~PEND_LEGAL) == '0)
		else $error("pending bit set for a nonexistent source");

	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (scan_idx_q != '0 && scan_idx_q <= SRC_W'(NUM_SOURCES)))
		else $error("scan index out of range");

	a_one_event: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> !(rsp_q.raise_request && rsp_q.drop_request)
			&& !(rsp_q.ack_found && (rsp_q.raise_request || rsp_q.drop_request)))
		else $error("result carries conflicting events");

	a_scan_stalls_queue: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && q_item.op == OP_ACK) |=> (state_q == ST_SCAN && !q_ready))
		else $error("acknowledge did not start a scan");

endmodule

### rtl/vectored_interrupt_controller_unit.sv
// ---------------------------------------------------------------------------
// vectored_interrupt_controller_unit
// Assert, withdraw and writes pass the front-end queue; their result is
// registered in the back-end output register. An acknowledge examines
// one source per cycle from 1 upward until a match or NUM_SOURCES.
// Throughput: one item per cycle except during an acknowledge scan or an
// output stall; a 2-entry queue keeps the input open until it fills. Reset
// sets all state to its reset values at once; no clearing pass.
// ---------------------------------------------------------------------------
module vectored_interrupt_controller_unit
	import vic_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	input  vic_in_t  req,
	output logic     rsp_valid,
	input  logic     rsp_ready,
	output vic_out_t rsp
);

	logic    q_valid;
	logic    q_ready;
	vic_op_t q_item;

	vic_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.q_valid   (q_valid),
		.q_ready   (q_ready),
		.q_item    (q_item)
	);

	vic_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_ready   (q_ready),
		.q_item    (q_item),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

### dv/tb_vectored_interrupt_controller_unit.sv
// ---------------------------------------------------------------------------
// tb_vectored_interrupt_controller_unit
// Drives assert, withdraw, acknowledge and register-write items into the
// interrupt controller and checks every reply against a cycle-free predictor
// of the pending word, per-level counts, stored vectors and control bytes.
// Directed cases come first, then shaped random traffic, partly under random stalls.
// ---------------------------------------------------------------------------
module tb_vectored_interrupt_controller_unit;
	import vic_pkg::*;

	localparam logic [2:0] CMD_UNUSED_FIRST = 3'd5;
	localparam logic [2:0] CMD_UNUSED_LAST  = 3'd7;
	localparam int QUIET_LIMIT = 3000;
	localparam int SETTLE_CYCLES = 20;

	logic     clk;
	logic     arst_n = 1'b0;
	logic     req_valid = 1'b0;
	logic     req_ready;
	vic_in_t  req = '0;
	logic     rsp_valid;
	logic     rsp_ready = 1'b0;
	vic_out_t rsp;

	vectored_interrupt_controller_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	// predictor state
	logic [7:0]  ctl_byte [16];
	logic [15:0] irq_mask;
	logic [15:0] irq_pend;
	logic [7:0]  dev_vec [16];
	logic [3:0]  lvl_cnt [8];

	vic_out_t irq_reply_q [$];
	vic_out_t want_reply;

	int  reply_errors = 0;
	int  items_sent = 0;
	int  raises_seen = 0;
	int  drops_seen = 0;
	int  acks_hit = 0;
	bit  valid_throttle = 1'b0;
	bit  ready_throttle = 1'b0;
	int  stall_left = 0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic void reset_irq_state();
		for (int i = 0; i < 16; i++) begin
			ctl_byte[i] = (i >= 1 && i <= NUM_SOURCES) ? CTRL_RESET[i] : 8'h00;
			dev_vec[i] = 8'h00;
		end
		for (int l = 0; l < LEVELS; l++)
			lvl_cnt[l] = 4'd0;
		irq_mask = MASK_RESET;
		irq_pend = 16'h0000;
	endfunction

	function automatic vic_out_t predict_irq_reply(input vic_in_t req_item);
		vic_out_t    r;
		logic [15:0] src_bit;
		logic [2:0]  lvl;
		logic        src_ok;
		r = '0;
		src_ok = (req_item.source >= 1) && (req_item.source <= NUM_SOURCES);
		src_bit = 16'd1 << req_item.source;
		lvl = ctl_byte[req_item.source][4:2];
		case (req_item.cmd)
			CMD_ASSERT: begin
				if (src_ok && (irq_mask & src_bit) == 0) begin
					dev_vec[req_item.source] = req_item.device_vector;
					if ((irq_pend & src_bit) == 0) begin
						irq_pend = irq_pend | src_bit;
						if (lvl_cnt[lvl] != COUNT_MAX)
							lvl_cnt[lvl] = lvl_cnt[lvl] + 4'd1;
						r.raise_request = 1'b1;
						r.request_level = lvl;
					end
				end
			end
			CMD_WITHDRAW: begin
				if (src_ok && (irq_mask & src_bit) == 0) begin
					dev_vec[req_item.source] = 8'h00;
					if ((irq_pend & src_bit) != 0) begin
						irq_pend = irq_pend & ~src_bit;
						// floor at zero: stale level leaves nothing to drop
						if (lvl_cnt[lvl] != 4'd0) begin
							lvl_cnt[lvl] = lvl_cnt[lvl] - 4'd1;
							if (lvl_cnt[lvl] == 4'd0) begin
								r.drop_request = 1'b1;
								r.request_level = lvl;
							end
						end
					end
				end
			end
			CMD_ACK: begin
				for (int s = 1; s <= NUM_SOURCES; s++) begin
					if (!r.ack_found && irq_pend[s] &&
					    ctl_byte[s][4:2] == req_item.ack_level) begin
						r.ack_found = 1'b1;
						r.ack_vector = ctl_byte[s][7] ?
							AUTOVEC_BASE + {5'd0, req_item.ack_level} : dev_vec[s];
					end
				end
			end
			CMD_WCTRL: begin
				if (src_ok)
					ctl_byte[req_item.source] = req_item.write_data[7:0];
			end
			CMD_WMASK: irq_mask = req_item.write_data;
			default: ;
		endcase
		r.pending_bits = irq_pend;
		return r;
	endfunction

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 3);
		if (r < 93)
			return $urandom_range(4, 8);
		return $urandom_range(15, 40);
	endfunction

	task automatic send_item(input vic_in_t req_item);
		int gap;
		gap = (valid_throttle && $urandom_range(0, 2) == 0) ? idle_len() : 0;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= req_item;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		irq_reply_q.push_back(predict_irq_reply(req_item));
		items_sent++;
	endtask

	task automatic send_cmd(input logic [2:0] cmd, input logic [3:0] source,
	                        input logic [7:0] dvec, input logic [2:0] lvl,
	                        input logic [15:0] wdata);
		vic_in_t req_item;
		req_item.cmd = cmd;
		req_item.source = source;
		req_item.device_vector = dvec;
		req_item.ack_level = lvl;
		req_item.write_data = wdata;
		send_item(req_item);
	endtask

	task automatic drain_replies();
		req_valid <= 1'b0;
		while (irq_reply_q.size() != 0) @(posedge clk);
	endtask

	// control byte with the given level and random other bits
	function automatic logic [15:0] ctl_with_level(input logic [2:0] lvl);
		return {8'($urandom), 1'($urandom), 2'($urandom), lvl, 2'($urandom)};
	endfunction

	function automatic logic [3:0] pick_source(input bit prefer_pending);
		logic [3:0] s;
		s = 4'($urandom_range(1, NUM_SOURCES));
		if (prefer_pending && irq_pend != 16'h0000)
			for (int tries = 0; tries < 32 && !irq_pend[s]; tries++)
				s = 4'($urandom_range(1, NUM_SOURCES));
		return s;
	endfunction

	function automatic vic_in_t random_irq_item();
		vic_in_t x;
		int      r;
		x.cmd = CMD_ASSERT;
		x.source = 4'($urandom);
		x.device_vector = 8'($urandom);
		x.ack_level = 3'($urandom);
		x.write_data = 16'($urandom);
		r = $urandom_range(0, 99);
		if (r < 34) begin
			x.source = pick_source(1'b0);
		end else if (r < 58) begin
			x.cmd = CMD_WITHDRAW;
			x.source = pick_source($urandom_range(0, 3) != 0);
		end else if (r < 78) begin
			x.cmd = CMD_ACK;
			if ($urandom_range(0, 3) != 0)
				x.ack_level = ctl_byte[pick_source(1'b1)][4:2];
		end else if (r < 87) begin
			x.cmd = CMD_WCTRL;
			x.source = pick_source(1'b0);
		end else if (r < 93) begin
			x.cmd = CMD_WMASK;
			r = $urandom_range(0, 99);
			// keep most sources open so pending traffic stays busy
			if (r < 40)
				x.write_data = 16'h0000;
			else if (r < 80)
				x.write_data = 16'($urandom & $urandom & $urandom);
		end else begin
			x.cmd = 3'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST));
		end
		if (x.cmd != CMD_ACK && $urandom_range(0, 24) == 0)
			x.source = ($urandom_range(0, 2) == 0) ? 4'd0 :
				4'(NUM_SOURCES + $urandom_range(1, 2));
		return x;
	endfunction

	task automatic test_masked_and_bad_sources();
		send_cmd(CMD_ACK, 4'($urandom), 8'($urandom), 3'd0, 16'($urandom));
		send_cmd(CMD_ASSERT, 4'd3, 8'hFF, 3'($urandom), 16'($urandom));
		send_cmd(CMD_WITHDRAW, 4'd13, 8'($urandom), 3'($urandom), 16'($urandom));
		for (int c = CMD_UNUSED_FIRST; c <= CMD_UNUSED_LAST; c++)
			send_cmd(3'(c), 4'($urandom), 8'($urandom), 3'($urandom), 16'($urandom));
		// only bit 0 and the bits above the last source: all sources open
		send_cmd(CMD_WMASK, 4'($urandom), 8'($urandom), 3'($urandom), 16'hC001);
		send_cmd(CMD_ASSERT, 4'd0, 8'($urandom), 3'($urandom), 16'($urandom));
		send_cmd(CMD_ASSERT, 4'd15, 8'($urandom), 3'($urandom), 16'($urandom));
		send_cmd(CMD_WCTRL, 4'd15, 8'($urandom), 3'($urandom), 16'hFFFF);
		send_cmd(CMD_WCTRL, 4'd0, 8'($urandom), 3'($urandom), 16'hFFFF);
	endtask

	task automatic test_vectors_and_ack();
		send_cmd(CMD_ASSERT, 4'd1, 8'hFF, 3'($urandom), 16'($urandom));
		send_cmd(CMD_ASSERT, 4'd1, 8'h00, 3'($urandom), 16'($urandom));
		send_cmd(CMD_ACK, 4'($urandom), 8'($urandom), 3'd1, 16'($urandom));
		send_cmd(CMD_ASSERT, 4'd13, 8'hA5, 3'($urandom), 16'($urandom));
		send_cmd(CMD_ACK, 4'($urandom), 8'($urandom), 3'd0, 16'($urandom));
		send_cmd(CMD_ASSERT, 4'd9, 8'h5A, 3'($urandom), 16'($urandom));
		send_cmd(CMD_ACK, 4'($urandom), 8'($urandom), 3'd0, 16'($urandom));
		send_cmd(CMD_WCTRL, 4'd7, 8'($urandom), 3'($urandom), 16'hFF9C);
		send_cmd(CMD_ASSERT, 4'd7, 8'h00, 3'($urandom), 16'($urandom));
		send_cmd(CMD_ACK, 4'($urandom), 8'($urandom), 3'd7, 16'($urandom));
		send_cmd(CMD_ACK, 4'($urandom), 8'($urandom), 3'd3, 16'($urandom));
	endtask

	task automatic test_withdraw_and_levels();
		send_cmd(CMD_WITHDRAW, 4'd2, 8'($urandom), 3'($urandom), 16'($urandom));
		send_cmd(CMD_WITHDRAW, 4'd9, 8'($urandom), 3'($urandom), 16'($urandom));
		send_cmd(CMD_WITHDRAW, 4'd13, 8'($urandom), 3'($urandom), 16'($urandom));
		// move a pending source to another level before withdrawing it
		send_cmd(CMD_WCTRL, 4'd1, 8'($urandom), 3'($urandom), 16'h0008);
		send_cmd(CMD_WITHDRAW, 4'd1, 8'($urandom), 3'($urandom), 16'($urandom));
		send_cmd(CMD_WMASK, 4'($urandom), 8'($urandom), 3'($urandom), 16'hFFFF);
		send_cmd(CMD_WITHDRAW, 4'd7, 8'($urandom), 3'($urandom), 16'($urandom));
		send_cmd(CMD_WMASK, 4'($urandom), 8'($urandom), 3'($urandom), 16'h0000);
		send_cmd(CMD_WITHDRAW, 4'd7, 8'($urandom), 3'($urandom), 16'($urandom));
	endtask

	task automatic test_count_saturation();
		logic [3:0] s;
		logic [2:0] lo;
		logic [2:0] hi;
		s = 4'($urandom_range(1, NUM_SOURCES));
		lo = 3'($urandom);
		hi = lo + 3'($urandom_range(1, 7));
		send_cmd(CMD_WMASK, 4'($urandom), 8'($urandom), 3'($urandom), 16'h0000);
		send_cmd(CMD_WITHDRAW, s, 8'($urandom), 3'($urandom), 16'($urandom));
		// raise at one level, withdraw at another: the first count only grows
		repeat (17) begin
			send_cmd(CMD_WCTRL, s, 8'($urandom), 3'($urandom), ctl_with_level(lo));
			send_cmd(CMD_ASSERT, s, 8'($urandom), 3'($urandom), 16'($urandom));
			send_cmd(CMD_WCTRL, s, 8'($urandom), 3'($urandom), ctl_with_level(hi));
			send_cmd(CMD_WITHDRAW, s, 8'($urandom), 3'($urandom), 16'($urandom));
		end
		send_cmd(CMD_WCTRL, s, 8'($urandom), 3'($urandom), ctl_with_level(lo));
		send_cmd(CMD_ASSERT, s, 8'($urandom), 3'($urandom), 16'($urandom));
		send_cmd(CMD_ACK, 4'($urandom), 8'($urandom), lo, 16'($urandom));
		send_cmd(CMD_WITHDRAW, s, 8'($urandom), 3'($urandom), 16'($urandom));
	endtask

	task automatic test_random_traffic(input int n, input bit gaps, input bit stalls);
		valid_throttle = gaps;
		ready_throttle = stalls;
		repeat (n)
			send_item(random_irq_item());
	endtask

	// response side stalls
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			rsp_ready <= 1'b0;
		end else if (ready_throttle && $urandom_range(0, 3) == 0) begin
			stall_left = idle_len() - 1;
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= 1'b1;
		end
	end

	task automatic check_field(input string name, input logic [15:0] want,
	                           input logic [15:0] got);
		if (got !== want) begin
			reply_errors++;
			$display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) begin
			if (irq_reply_q.size() == 0) begin
				reply_errors++;
				$display("%0t: unexpected reply, expected none, actual %h", $time, rsp);
			end else begin
				want_reply = irq_reply_q.pop_front();
				check_field("raise_request", 16'(want_reply.raise_request),
				            16'(rsp.raise_request));
				check_field("drop_request", 16'(want_reply.drop_request),
				            16'(rsp.drop_request));
				check_field("request_level", 16'(want_reply.request_level),
				            16'(rsp.request_level));
				check_field("ack_found", 16'(want_reply.ack_found), 16'(rsp.ack_found));
				check_field("ack_vector", 16'(want_reply.ack_vector), 16'(rsp.ack_vector));
				check_field("pending_bits", want_reply.pending_bits, rsp.pending_bits);
				raises_seen += want_reply.raise_request;
				drops_seen += want_reply.drop_request;
				acks_hit += want_reply.ack_found;
			end
		end
	end

	// end the run when no handshake completes for too long
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		reset_irq_state();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_masked_and_bad_sources();
		test_vectors_and_ack();
		test_withdraw_and_levels();
		test_count_saturation();
		test_random_traffic(150, 1'b0, 1'b0);
		test_random_traffic(200, 1'b1, 1'b1);
		drain_replies();
		test_random_traffic(150, 1'b0, 1'b1);
		test_random_traffic(95, 1'b1, 1'b0);

		req_valid <= 1'b0;
		while (irq_reply_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Sent %0d items: %0d requests raised, %0d dropped, %0d acknowledges answered.",
		         items_sent, raises_seen, drops_seen, acks_hit);
		$display("Covered masked and bad sources, stale counts and autovectors under stalls.");
		if (reply_errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
